// File: rtl/pbook_pkg.sv
// Shared types, sizes and codes for the price level order book.
`timescale 1ns / 1ps
`default_nettype none
package pbook_pkg;

  localparam int MAX_ORDERS      = 1024;
  localparam int LEVELS_PER_SIDE = 256;
  localparam int NUM_LEVELS      = 2 * LEVELS_PER_SIDE;
  localparam int OAW             = $clog2(MAX_ORDERS);
  localparam int LAW             = $clog2(NUM_LEVELS);
  localparam int SCAN_LEN        = (MAX_ORDERS > NUM_LEVELS) ? MAX_ORDERS : NUM_LEVELS;
  localparam int CW              = $clog2(SCAN_LEN + 1);

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_EXEC = 3'd1;
  localparam logic [2:0] CMD_CANC = 3'd2;
  localparam logic [2:0] CMD_DEL  = 3'd3;
  localparam logic [2:0] CMD_REPL = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_UNK   = 3'd2;
  localparam logic [2:0] ST_ZERO  = 3'd3;
  localparam logic [2:0] ST_MANY  = 3'd4;
  localparam logic [2:0] ST_CROSS = 3'd5;
  localparam logic [2:0] ST_BADR  = 3'd6;
  localparam logic [2:0] ST_FULL  = 3'd7;

  typedef struct packed {
    logic        vld;
    logic [63:0] key;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } order_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] price;
    logic [41:0] total;
    logic [10:0] count;
  } level_t;

  localparam int ORD_W = $bits(order_t);
  localparam int LVL_W = $bits(level_t);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OSCAN, S_CHECK, S_LSCAN, S_FINAL, S_RED, S_PLACE, S_TOPS, S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/pbook_ram.sv
// Generic simple dual port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pbook_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/price_level_order_book.sv
// Top level of the price level order book: sequencer, scans and book state.
//
// Input channel (in_valid/in_ready) carries one message word: cmd, ref_req,
// new_ref, side, shares, price. Output channel (out_valid/out_ready) carries
// one result word per message: status, best bid/ask, touched level totals
// and total resting shares.
// One message at a time. Every message scans the order memory once and
// passes a check state; accepted ones also scan one side of the level
// memory and pass a decision state, and unless the order or level table is
// full they then take one or two write states (reduce, place) and rescan
// all levels for the best prices. Each memory has a single read port,
// walked one entry per cycle during a scan. A message rejected at the
// checks or as table full skips the rest and goes straight to out_valid.
// After reset a clearing pass writes every entry of both memories, one per
// cycle; in_ready stays low until it ends.
// The result word is held in registers until out_ready; a new message is
// taken only after the previous word has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module price_level_order_book (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] ref_req,
  input  wire logic [63:0] new_ref,
  input  wire logic        side,
  input  wire logic [31:0] shares,
  input  wire logic [31:0] price,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      bid_price,
  output logic             bid_valid,
  output logic [31:0]      ask_price,
  output logic             ask_valid,
  output logic [41:0]      level_shares,
  output logic [10:0]      level_orders,
  output logic [41:0]      resting_total
);
  import pbook_pkg::*;

  state_t state, state_next;

  // scan sequencer
  logic [CW-1:0]  sc;
  logic           pend;
  logic [CW-1:0]  pidx;
  logic [CW-1:0]  scan_len;
  logic           issue;
  logic           scan_done;

  // latched message
  logic [2:0]  r_cmd;
  logic [63:0] r_ref, r_nref;
  logic        r_side;
  logic [31:0] r_qty, r_price;

  // order scan results
  logic           o_hit, n_hit, f_hit;
  logic [OAW-1:0] o_idx, f_idx;
  logic           o_side;
  logic [31:0]    o_price, o_qty;

  // level scan results
  logic           sside;
  logic [31:0]    pnew, pold;
  logic           lm_hit, lo_hit, lf_hit, lo_free;
  logic [LAW-1:0] lm_idx, lo_idx, lf_idx;
  logic [41:0]    lm_tot, lo_tot;
  logic [10:0]    lm_cnt, lo_cnt;

  // top of book and totals
  logic [31:0] top_bid, top_ask, tb, ta;
  logic        bid_ok, ask_ok, tbo, tao;
  logic [41:0] rsum;

  // memories
  logic           ord_we, lvl_we;
  logic [OAW-1:0] ord_waddr, ord_raddr;
  logic [LAW-1:0] lvl_waddr, lvl_raddr;
  order_t         ord_wdata, ord_rdata;
  level_t         lvl_wdata, lvl_rdata;

  pbook_ram #(.WIDTH(ORD_W), .DEPTH(MAX_ORDERS)) u_orders (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  pbook_ram #(.WIDTH(LVL_W), .DEPTH(NUM_LEVELS)) u_levels (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  // reduce arithmetic
  logic [31:0] rq, newq;
  logic [41:0] red_tot;
  logic [10:0] red_cnt;
  logic        red_free;
  // place target
  logic           same_px, use_lo, use_lm;
  logic [LAW-1:0] new_lidx;
  logic [41:0]    base_tot;
  logic [10:0]    base_cnt;
  // checks
  logic        cross_chk;
  logic [31:0] cross_px;
  logic        cross_side;
  logic [2:0]  chk_st;
  logic        add_full, repl_room;
  logic [LAW-1:0] lbase;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign bid_price = top_bid;
  assign bid_valid = bid_ok;
  assign ask_price = top_ask;
  assign ask_valid = ask_ok;
  assign resting_total = rsum;

  assign lbase = sside ? LAW'(LEVELS_PER_SIDE) : '0;

  always_comb begin
    rq       = (r_cmd == CMD_EXEC || r_cmd == CMD_CANC) ? r_qty : o_qty;
    newq     = o_qty - rq;
    red_tot  = lo_tot - {10'd0, rq};
    red_cnt  = lo_cnt;
    if (newq == 32'd0) begin
      red_cnt = (lo_cnt != 11'd0) ? lo_cnt - 11'd1 : 11'd0;
    end
    red_free = lo_hit && (newq == 32'd0) && (red_cnt == 11'd0);

    same_px  = (pnew == pold);
    use_lo   = same_px && lo_hit && !lo_free;
    use_lm   = !same_px && lm_hit;
    if (lf_hit && (!lo_free || lf_idx < lo_idx)) begin
      new_lidx = lf_idx;
    end else begin
      new_lidx = lo_idx;
    end
    base_tot = '0;
    base_cnt = '0;
    if (use_lo) begin
      new_lidx = lo_idx;
      base_tot = lo_tot;
      base_cnt = lo_cnt;
    end else if (use_lm) begin
      new_lidx = lm_idx;
      base_tot = lm_tot;
      base_cnt = lm_cnt;
    end

    cross_side = (r_cmd == CMD_REPL) ? o_side : r_side;
    cross_px   = r_price;
    cross_chk  = cross_side ? (bid_ok && cross_px <= top_bid)
                            : (ask_ok && cross_px >= top_ask);

    case (r_cmd)
      CMD_ADD: begin
        if (r_qty == 32'd0) chk_st = ST_ZERO;
        else if (o_hit)     chk_st = ST_DUP;
        else if (cross_chk) chk_st = ST_CROSS;
        else                chk_st = ST_OK;
      end
      CMD_EXEC, CMD_CANC: begin
        if (!o_hit)               chk_st = ST_UNK;
        else if (r_qty == 32'd0)  chk_st = ST_ZERO;
        else if (r_qty > o_qty)   chk_st = ST_MANY;
        else                      chk_st = ST_OK;
      end
      CMD_DEL: begin
        chk_st = o_hit ? ST_OK : ST_UNK;
      end
      CMD_REPL: begin
        if (r_ref == r_nref)     chk_st = ST_BADR;
        else if (!o_hit)         chk_st = ST_UNK;
        else if (n_hit)          chk_st = ST_DUP;
        else if (r_qty == 32'd0) chk_st = ST_ZERO;
        else if (cross_chk)      chk_st = ST_CROSS;
        else                     chk_st = ST_OK;
      end
      default: chk_st = ST_BADR;
    endcase

    add_full  = !f_hit || (!lm_hit && !lf_hit);
    repl_room = lm_hit || lf_hit || (lo_hit && lo_cnt == 11'd1);
  end

  // scan control
  always_comb begin
    case (state)
      S_OSCAN: scan_len = CW'(MAX_ORDERS);
      S_LSCAN: scan_len = CW'(LEVELS_PER_SIDE);
      S_TOPS:  scan_len = CW'(NUM_LEVELS);
      default: scan_len = CW'(SCAN_LEN);
    endcase
    issue     = (sc < scan_len);
    scan_done = !issue && !pend;
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    ord_we     = 1'b0;
    lvl_we     = 1'b0;
    ord_waddr  = o_idx;
    lvl_waddr  = lo_idx;
    ord_wdata  = '0;
    lvl_wdata  = '0;
    ord_raddr  = sc[OAW-1:0];
    lvl_raddr  = (state == S_LSCAN) ? lbase + sc[LAW-1:0] : sc[LAW-1:0];
    case (state)
      S_CLEAR: begin
        ord_we    = (sc < CW'(MAX_ORDERS));
        lvl_we    = (sc < CW'(NUM_LEVELS));
        ord_waddr = sc[OAW-1:0];
        lvl_waddr = sc[LAW-1:0];
        if (sc == CW'(SCAN_LEN)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_OSCAN;
      end
      S_OSCAN: begin
        if (scan_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = (chk_st == ST_OK) ? S_LSCAN : S_DONE;
      end
      S_LSCAN: begin
        if (scan_done) state_next = S_FINAL;
      end
      S_FINAL: begin
        case (r_cmd)
          CMD_ADD:  state_next = add_full ? S_DONE : S_PLACE;
          CMD_REPL: state_next = repl_room ? S_RED : S_DONE;
          default:  state_next = S_RED;
        endcase
      end
      S_RED: begin
        lvl_we    = lo_hit;
        lvl_waddr = lo_idx;
        lvl_wdata = '{vld: !red_free, price: pold, total: red_tot, count: red_cnt};
        ord_we    = (r_cmd != CMD_REPL);
        ord_waddr = o_idx;
        ord_wdata = '{vld: newq != 32'd0, key: r_ref, side: sside, price: pold, qty: newq};
        state_next = (r_cmd == CMD_REPL) ? S_PLACE : S_TOPS;
      end
      S_PLACE: begin
        lvl_we    = 1'b1;
        lvl_waddr = new_lidx;
        lvl_wdata = '{vld: 1'b1, price: pnew, total: base_tot + {10'd0, r_qty},
                      count: base_cnt + 11'd1};
        ord_we    = 1'b1;
        ord_waddr = (r_cmd == CMD_REPL) ? o_idx : f_idx;
        ord_wdata = '{vld: 1'b1, key: (r_cmd == CMD_REPL) ? r_nref : r_ref,
                      side: sside, price: pnew, qty: r_qty};
        state_next = S_TOPS;
      end
      S_TOPS: begin
        if (scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // scan counter: reads issued at sc, data seen in the next cycle at pidx
  always_ff @(posedge clk) begin
    if (rst) begin
      sc   <= '0;
      pend <= 1'b0;
    end else if (state != state_next) begin
      sc   <= '0;
      pend <= 1'b0;
    end else if (state == S_CLEAR) begin
      sc <= sc + CW'(1);
    end else if (state == S_OSCAN || state == S_LSCAN || state == S_TOPS) begin
      if (issue) sc <= sc + CW'(1);
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LSCAN) begin
      pidx <= CW'(lbase + sc[LAW-1:0]);
    end else begin
      pidx <= sc;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      top_bid <= '0;
      top_ask <= '0;
      bid_ok  <= 1'b0;
      ask_ok  <= 1'b0;
      rsum    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          r_cmd   <= cmd;
          r_ref   <= ref_req;
          r_nref  <= new_ref;
          r_side  <= side;
          r_qty   <= shares;
          r_price <= price;
          o_hit   <= 1'b0;
          n_hit   <= 1'b0;
          f_hit   <= 1'b0;
        end
        S_OSCAN: begin
          if (pend) begin
            if (ord_rdata.vld && ord_rdata.key == r_ref && !o_hit) begin
              o_hit   <= 1'b1;
              o_idx   <= pidx[OAW-1:0];
              o_side  <= ord_rdata.side;
              o_price <= ord_rdata.price;
              o_qty   <= ord_rdata.qty;
            end
            if (ord_rdata.vld && ord_rdata.key == r_nref) n_hit <= 1'b1;
            if (!ord_rdata.vld && !f_hit) begin
              f_hit <= 1'b1;
              f_idx <= pidx[OAW-1:0];
            end
          end
        end
        S_CHECK: begin
          status       <= chk_st;
          level_shares <= '0;
          level_orders <= '0;
          lm_hit  <= 1'b0;
          lo_hit  <= 1'b0;
          lf_hit  <= 1'b0;
          lo_free <= 1'b0;
          if (r_cmd == CMD_ADD) begin
            sside <= r_side;
            pnew  <= r_price;
            pold  <= r_price;
          end else if (r_cmd == CMD_REPL) begin
            sside <= o_side;
            pnew  <= r_price;
            pold  <= o_price;
          end else begin
            sside <= o_side;
            pnew  <= o_price;
            pold  <= o_price;
          end
        end
        S_LSCAN: begin
          if (pend) begin
            if (lvl_rdata.vld && lvl_rdata.price == pnew && !lm_hit) begin
              lm_hit <= 1'b1;
              lm_idx <= pidx[LAW-1:0];
              lm_tot <= lvl_rdata.total;
              lm_cnt <= lvl_rdata.count;
            end
            if (lvl_rdata.vld && lvl_rdata.price == pold && !lo_hit) begin
              lo_hit <= 1'b1;
              lo_idx <= pidx[LAW-1:0];
              lo_tot <= lvl_rdata.total;
              lo_cnt <= lvl_rdata.count;
            end
            if (!lvl_rdata.vld && !lf_hit) begin
              lf_hit <= 1'b1;
              lf_idx <= pidx[LAW-1:0];
            end
          end
        end
        S_FINAL: begin
          if ((r_cmd == CMD_ADD && add_full) || (r_cmd == CMD_REPL && !repl_room)) begin
            status <= ST_FULL;
          end
        end
        S_RED: begin
          rsum    <= rsum - {10'd0, rq};
          lo_tot  <= red_tot;
          lo_cnt  <= red_cnt;
          lo_free <= red_free;
          if (lo_hit && !red_free) begin
            level_shares <= red_tot;
            level_orders <= red_cnt;
          end
        end
        S_PLACE: begin
          rsum         <= rsum + {10'd0, r_qty};
          level_shares <= base_tot + {10'd0, r_qty};
          level_orders <= base_cnt + 11'd1;
        end
        S_TOPS: begin
          if (state_next != S_TOPS) begin
            top_bid <= tb;
            bid_ok  <= tbo;
            top_ask <= ta;
            ask_ok  <= tao;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // running best prices over the level scan
  always_ff @(posedge clk) begin
    if (state != S_TOPS) begin
      tb  <= '0;
      ta  <= '0;
      tbo <= 1'b0;
      tao <= 1'b0;
    end else if (pend && lvl_rdata.vld) begin
      if (pidx < CW'(LEVELS_PER_SIDE)) begin
        if (!tbo || lvl_rdata.price > tb) begin
          tb  <= lvl_rdata.price;
          tbo <= 1'b1;
        end
      end else if (!tao || lvl_rdata.price < ta) begin
        ta  <= lvl_rdata.price;
        tao <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_cross: assert property (@(posedge clk) disable iff (rst)
    out_valid && bid_valid && ask_valid |-> bid_price < ask_price)
    else $error("book crossed at result");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> level_shares == 42'd0 && level_orders == 11'd0)
    else $error("rejected word carries level totals");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE || state == S_DONE |-> !ord_we && !lvl_we)
    else $error("memory write outside processing");
  a_bid_zero: assert property (@(posedge clk) disable iff (rst)
    !bid_ok |-> top_bid == 32'd0)
    else $error("bid price without bid level");
  a_book_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(rsum) && $stable(top_ask))
    else $error("book changed while result stalled");
`endif

endmodule
`default_nettype wire
